### hw/rtl/p80_pkg.sv
// p80_pkg: shared types, constants and round functions for the PRESENT-80 encryptor
// no dependencies; imported by the controller, datapath and top level
package p80_pkg;

  localparam int unsigned BLK_W     = 64;
  localparam int unsigned KEY_W     = 80;
  localparam int unsigned KEY_LO_W  = 64;
  localparam int unsigned KEY_HI_W  = 16;
  localparam int unsigned RND_W     = 5;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [RND_W-1:0] LAST_ROUND  = 5'd31;
  localparam logic [RND_W-1:0] FIRST_ROUND = 5'd1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } p80_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic round;
    logic finish;
  } p80_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_round;
  } p80_sts_t;

  localparam logic [3:0] SBOX [16] = '{
    4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
    4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };

  function automatic logic [BLK_W-1:0] sub_layer(input logic [BLK_W-1:0] x);
    logic [BLK_W-1:0] y;
    y = '0;
    for (int i = 0; i < BLK_W / 4; i++) begin
      y[4*i +: 4] = SBOX[x[4*i +: 4]];
    end
    return y;
  endfunction

  // bit b moves to b/4 + 16*(b%4)
  function automatic logic [BLK_W-1:0] perm_layer(input logic [BLK_W-1:0] x);
    logic [BLK_W-1:0] y;
    y = '0;
    for (int b = 0; b < BLK_W; b++) begin
      y[(b / 4) + 16 * (b % 4)] = x[b];
    end
    return y;
  endfunction

  // rotate right by 19, s-box on top nibble, round number into bits 19..15
  function automatic logic [KEY_W-1:0] key_update(input logic [KEY_W-1:0] k,
                                                  input logic [RND_W-1:0] rnd);
    logic [KEY_W-1:0] rot;
    rot = {k[18:0], k[KEY_W-1:19]};
    rot[KEY_W-1 -: 4] = SBOX[rot[KEY_W-1 -: 4]];
    rot[19:15] = rot[19:15] ^ rnd;
    return rot;
  endfunction

endpackage

### hw/rtl/p80_ctrl.sv
// p80_ctrl: request sequencer for the PRESENT-80 encryptor
// depends on p80_pkg; drives commands to p80_datapath
module p80_ctrl import p80_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  p80_sts_t sts,
  output p80_cmd_t cmd,
  output logic     busy,
  output logic     out_valid
);

  p80_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.round = 1'b1;
        if (sts.last_round) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.finish    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

### hw/rtl/p80_datapath.sv
// p80_datapath: key configuration, round state, key schedule and output register
// depends on p80_pkg; commanded by p80_ctrl
module p80_datapath import p80_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  p80_cmd_t             cmd,
  output p80_sts_t             sts,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_LO_W-1:0]  cfg_wdata,
  input  logic [BLK_W-1:0]     plaintext,
  output logic [BLK_W-1:0]     ciphertext
);

  logic [KEY_LO_W-1:0] key_low_r;
  logic [KEY_HI_W-1:0] key_high_r;
  logic [BLK_W-1:0]    blk_r, blk_nxt;
  logic [KEY_W-1:0]    rkey_r, rkey_nxt;
  logic [RND_W-1:0]    rnd_r, rnd_nxt;
  logic [BLK_W-1:0]    ct_r;
  logic [BLK_W-1:0]    mixed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_LOW:  key_low_r  <= cfg_wdata;
        REG_KEY_HIGH: key_high_r <= cfg_wdata[KEY_HI_W-1:0];
        default: ;
      endcase
    end
  end

  assign mixed = blk_r ^ rkey_r[KEY_W-1 -: BLK_W];

  always_comb begin
    blk_nxt  = blk_r;
    rkey_nxt = rkey_r;
    rnd_nxt  = rnd_r;
    if (cmd.load) begin
      blk_nxt  = plaintext;
      rkey_nxt = {key_high_r, key_low_r};
      rnd_nxt  = FIRST_ROUND;
    end else if (cmd.round) begin
      blk_nxt  = perm_layer(sub_layer(mixed));
      rkey_nxt = key_update(rkey_r, rnd_r);
      rnd_nxt  = rnd_r + RND_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    blk_r  <= blk_nxt;
    rkey_r <= rkey_nxt;
    rnd_r  <= rnd_nxt;
    if (cmd.finish) begin
      ct_r <= mixed;
    end
  end

  assign sts.last_round = (rnd_r == LAST_ROUND);
  assign ciphertext     = ct_r;

endmodule

### hw/rtl/present80_block_encrypt.sv
// present80_block_encrypt: PRESENT-80 block encryption, one round per clock
// depends on p80_pkg, p80_ctrl and p80_datapath
//
// sequence: a taken request is loaded, runs 31 rounds and a final key addition; the
//   ciphertext and the out_valid strobe are registered together in that final step
// a new request is taken only once the block is idle again, set by the single shared round unit
// busy is high from the accepting edge until the final key addition is done
// reset (rst_n low, synchronous) returns to idle, drops out_valid and clears the key
// results cannot be held off: out_valid is a one-cycle strobe
module present80_block_encrypt import p80_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // request channel
  input  logic                 start,
  output logic                 busy,
  input  logic [BLK_W-1:0]     in_plaintext,
  // result channel
  output logic                 out_valid,
  output logic [BLK_W-1:0]     out_ciphertext,
  // key configuration: index 0 key bits 63..0, index 1 key bits 79..64
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_LO_W-1:0]  cfg_wdata
);

  // command and status between sequencer and round datapath
  p80_cmd_t cmd;
  p80_sts_t sts;

  // sequencer: idle -> rounds until the last round -> final key addition -> idle
  p80_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // datapath: key registers, block state, key schedule and ciphertext register
  p80_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .plaintext  (in_plaintext),
    .ciphertext (out_ciphertext)
  );

endmodule

### hw/rtl/p80_checker.sv
// p80_checker: port-level assertions for present80_block_encrypt
// depends on p80_pkg; attached to the top level by the bind below
module p80_checker import p80_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_valid,
  input logic [BLK_W-1:0] out_ciphertext
);

  // an accepted request makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after request");

  // every accepted request yields its result strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##33 out_valid)
    else $error("result missing 33 cycles after request");

  // result strobe lasts one cycle and never overlaps busy
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy ##1 !out_valid)
    else $error("result strobe malformed");

  // busy only rises after a request
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy raised without request");

  // a strobed ciphertext carries no unknown bits
  a_ct_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_ciphertext))
    else $error("ciphertext unknown while strobed");

endmodule

bind present80_block_encrypt p80_checker u_p80_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_ciphertext (out_ciphertext)
);

### dv/tb_present80_block_encrypt.sv
// tb_present80_block_encrypt: self-checking testbench for the PRESENT-80 block encryptor
// depends on p80_pkg and present80_block_encrypt; holds its own cipher model in a scoreboard
// directed blocks and keys first, then random blocks under changing keys and sender gaps
module tb_present80_block_encrypt import p80_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // s-box packed one nibble per entry, entry 0 in the low nibble
  localparam logic [63:0] SBOX_NIBBLES = 64'h2174_8FE3_DA09_B65C;
  localparam int unsigned NUM_ROUNDS   = 31;
  // covers the slowest correct run: 1516 requests, each busy and after the longest gap, plus drains
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned MAX_GAP      = 40;
  localparam int unsigned CHUNK_ITEMS  = 100;
  localparam int unsigned CHUNKS       = 5;

  // cipher model and store of expected ciphertexts
  class cipher_scoreboard;
    logic [KEY_LO_W-1:0] key_lo;
    logic [KEY_HI_W-1:0] key_hi;
    logic [BLK_W-1:0]    expected_ct[$];
    int unsigned         errors;

    function new();
      key_lo = '0;
      key_hi = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [KEY_LO_W-1:0] data);
      case (idx)
        REG_KEY_LOW:  key_lo = data;
        REG_KEY_HIGH: key_hi = data[KEY_HI_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [3:0] sub_nibble(logic [3:0] n);
      return SBOX_NIBBLES[4*n +: 4];
    endfunction

    function logic [BLK_W-1:0] present80_encrypt(logic [BLK_W-1:0] pt);
      logic [KEY_W-1:0] k;
      logic [BLK_W-1:0] s;
      logic [BLK_W-1:0] t;
      logic [RND_W-1:0] rnd;
      s = pt;
      k = {key_hi, key_lo};
      for (int r = 1; r <= NUM_ROUNDS; r++) begin
        rnd = r[RND_W-1:0];
        // add round key, then s-box layer
        s = s ^ k[KEY_W-1:16];
        for (int i = 0; i < 16; i++) s[4*i +: 4] = sub_nibble(s[4*i +: 4]);
        // bit b goes to 16*(b mod 4) + b/4
        t = '0;
        for (int b = 0; b < BLK_W; b++) t[16*(b%4) + b/4] = s[b];
        s = t;
        // key schedule: rotate right 19, s-box top nibble, round number into 19..15
        k = {k[18:0], k[KEY_W-1:19]};
        k[KEY_W-1 -: 4] = sub_nibble(k[KEY_W-1 -: 4]);
        k[19:15] = k[19:15] ^ rnd;
      end
      return s ^ k[KEY_W-1:16];
    endfunction

    function void note_request(logic [BLK_W-1:0] pt);
      expected_ct.push_back(present80_encrypt(pt));
    endfunction

    function void check_result(logic [BLK_W-1:0] ct);
      logic [BLK_W-1:0] exp_ct;
      if (expected_ct.size() == 0) begin
        $error("ciphertext: no request pending, actual %h", ct);
        errors++;
      end else begin
        exp_ct = expected_ct.pop_front();
        if (ct !== exp_ct) begin
          $error("ciphertext: expected %h, actual %h", exp_ct, ct);
          errors++;
        end
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [BLK_W-1:0]     in_plaintext = '0;
  logic                 out_valid;
  logic [BLK_W-1:0]     out_ciphertext;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_KEY_LOW;
  logic [KEY_LO_W-1:0]  cfg_wdata = '0;

  cipher_scoreboard sb = new();
  int unsigned      cycles = 0;
  int unsigned      idle_pct = 0;

  present80_block_encrypt u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_plaintext  (in_plaintext),
    .out_valid     (out_valid),
    .out_ciphertext(out_ciphertext),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  // 20 ns clock
  always #10 clk = ~clk;

  // watchdog: a hung block or a lost result ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result monitor: out_valid is a one-cycle strobe, no backpressure possible
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) sb.check_result(out_ciphertext);
  end

  // one request: optional sender gap, then hold start until the block takes it.
  // start is left high after acceptance so a back-to-back request keeps one
  // assignment per edge; the next call or stop_requests decides what follows
  task automatic send_block(logic [BLK_W-1:0] pt);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(99) < idle_pct) gap = $urandom_range(MAX_GAP, 1);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_plaintext <= pt;
    do @(posedge clk); while (busy !== 1'b0);
    // start was high and busy low at this edge: request taken
    sb.note_request(pt);
  endtask

  task automatic stop_requests();
    start <= 1'b0;
  endtask

  // wait until every ciphertext is back and the block is idle, then settle
  task automatic drain();
    stop_requests();
    do @(posedge clk); while (sb.expected_ct.size() != 0 || busy !== 1'b0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_key_reg(logic [CFG_IDX_W-1:0] idx, logic [KEY_LO_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // key_high gets full-width data so stray upper bits are exercised too
  task automatic load_key(logic [KEY_LO_W-1:0] lo, logic [KEY_LO_W-1:0] hi_raw);
    if ($urandom_range(1)) begin
      write_key_reg(REG_KEY_LOW, lo);
      write_key_reg(REG_KEY_HIGH, hi_raw);
    end else begin
      write_key_reg(REG_KEY_HIGH, hi_raw);
      write_key_reg(REG_KEY_LOW, lo);
    end
  endtask

  function automatic logic [63:0] pick_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(63);
      3:       return ~(64'd1 << $urandom_range(63));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // several random-key chunks per phase, key reloaded with the block idle
  task automatic run_phase(int unsigned pct);
    idle_pct = pct;
    for (int c = 0; c < CHUNKS; c++) begin
      drain();
      load_key(pick_word(), pick_word());
      for (int i = 0; i < CHUNK_ITEMS; i++) send_block(pick_word());
    end
  endtask

  initial begin
    // reset held low from the start, then released
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // encrypt before any key write: all-zero reset key
    idle_pct = 0;
    send_block('0);
    send_block('1);
    send_block({$urandom, $urandom});

    // all-ones key, stray high bits set in the key_high write
    drain();
    load_key('1, '1);
    send_block('0);
    send_block('1);
    send_block(64'h5555_5555_5555_5555);
    send_block(64'hAAAA_AAAA_AAAA_AAAA);
    send_block(64'h0000_0000_0000_0001);
    send_block(64'h8000_0000_0000_0000);

    // stray high bits only: key_high must mask back to zero
    drain();
    load_key('0, 64'hFFFF_FFFF_FFFF_0000);
    send_block('0);
    send_block('1);
    send_block(64'h0123_4567_89AB_CDEF);

    // single-bit keys at both ends of the key register
    drain();
    load_key(64'h0000_0000_0000_0001, 64'h0);
    send_block('0);
    send_block(64'hFEDC_BA98_7654_3210);
    drain();
    load_key(64'h0, 64'h8000);
    send_block('0);
    send_block('1);

    // random part: sender idles 34%, then 58%, then never
    run_phase(34);
    run_phase(58);
    run_phase(0);

    drain();
    if (sb.errors == 0 && sb.expected_ct.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
